[sv/bpa_pkg.sv]
// Shared constants and types for the bitmap page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int unsigned MAX_PAGES_DEF  = 16384;
    localparam int unsigned PAGE_BYTES_DEF = 4096;

    localparam int CNT_W   = 15;
    localparam int ADDR_W  = 32;
    localparam int REQ_W   = 2;
    localparam int CFG_W   = 15;

    localparam logic [REQ_W-1:0] REQ_INIT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

    localparam logic CFG_TOTAL = 1'b0;
    localparam logic CFG_FIRST = 1'b1;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic clear_step; // mark one page used in the post-reset pass
        logic start;      // latch the request and set up
        logic init_step;  // write one page bit of the init sweep
        logic scan_step;  // examine one page of the first-fit search
        logic mark_step;  // set one page used
        logic free_step;  // apply the free request
        logic finish;     // load the result register
    } bpa_cmd_t;

    // Status returned to the controller
    typedef struct packed {
        logic init_last;
        logic scan_done;
        logic found;
        logic mark_last;
    } bpa_sts_t;

endpackage

[sv/bpa_datapath.sv]
// Bitmap storage, counters and search logic of the page allocator.
`timescale 1ns / 1ps

module bpa_datapath #(
    parameter int unsigned MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
    parameter int unsigned PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bpa_pkg::bpa_cmd_t         cmd,
    output bpa_pkg::bpa_sts_t         sts,
    input  logic [bpa_pkg::REQ_W-1:0] req_type,
    input  logic [bpa_pkg::CNT_W-1:0] page_count,
    input  logic [bpa_pkg::ADDR_W-1:0] free_address,
    input  logic [bpa_pkg::CFG_W-1:0] total_cfg,
    input  logic [bpa_pkg::CFG_W-1:0] first_cfg,
    output logic                      status,
    output logic [bpa_pkg::ADDR_W-1:0] base_address,
    output logic [bpa_pkg::CNT_W-1:0] free_pages
);

    localparam int PG_W   = $clog2(MAX_PAGES + 1);
    localparam int IDX_W  = $clog2(MAX_PAGES);
    localparam int SH_W   = $clog2(PAGE_BYTES);
    localparam int ADDR_W_L = bpa_pkg::ADDR_W;

    // One bit per page, 1 = used; the page is the memory address
    logic mem [MAX_PAGES];
    logic rd_reg;

    logic [PG_W-1:0]  total_reg, total_next;
    logic [PG_W-1:0]  ptr_reg, ptr_next;
    logic [PG_W-1:0]  start_reg, start_next;
    logic [PG_W-1:0]  run_reg, run_next;
    logic [PG_W-1:0]  cnt_reg, cnt_next;
    logic [PG_W-1:0]  first_reg, first_next;
    logic [PG_W-1:0]  fpg_reg, fpg_next;
    logic [bpa_pkg::REQ_W-1:0] req_reg, req_next;
    logic [bpa_pkg::CNT_W-1:0] fc_reg, fc_next;
    logic found_reg, found_next;
    logic fail_reg, fail_next;
    logic oor_reg, oor_next;

    logic [PG_W-1:0] total_eff;
    logic [PG_W-1:0] cnt_ext;
    logic [PG_W-1:0] first_ext;
    logic [ADDR_W_L-1:0] page_of_addr;

    logic            wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic            wr_val;
    logic [IDX_W-1:0] rd_idx;
    logic [ADDR_W_L+SH_W-1:0] base_wide;

    // Clamp the configured total to capacity
    always_comb
    begin
        if (32'(total_cfg) > 32'(MAX_PAGES))
            total_eff = PG_W'(MAX_PAGES);
        else
            total_eff = PG_W'(total_cfg);
        cnt_ext      = PG_W'(page_count);
        first_ext    = PG_W'(first_cfg);
        page_of_addr = free_address >> SH_W;
    end

    // Bitmap read, registered: rd_reg holds the bit of the page in ptr_reg
    assign rd_idx = ptr_next[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_val;
        rd_reg <= mem[rd_idx];
    end

    // Next-state datapath
    always_comb
    begin
        total_next    = total_reg;
        ptr_next      = ptr_reg;
        start_next    = start_reg;
        run_next      = run_reg;
        cnt_next      = cnt_reg;
        first_next    = first_reg;
        fpg_next      = fpg_reg;
        req_next      = req_reg;
        fc_next       = fc_reg;
        found_next    = found_reg;
        fail_next     = fail_reg;
        oor_next      = oor_reg;
        wr_en         = 1'b0;
        wr_idx        = ptr_reg[IDX_W-1:0];
        wr_val        = 1'b1;

        // Mark every page used after reset, one page per step
        if (cmd.clear_step)
        begin
            wr_en    = 1'b1;
            wr_val   = 1'b1;
            ptr_next = ptr_reg + 1'b1;
        end

        if (cmd.start)
        begin
            total_next = total_eff;
            req_next   = req_type;
            cnt_next   = cnt_ext;
            first_next = first_ext;
            ptr_next   = '0;
            run_next   = '0;
            start_next = '0;
            found_next = 1'b0;
            fail_next  = (page_count == '0) || (cnt_ext > total_eff);
            oor_next   = (page_of_addr >= ADDR_W_L'(total_eff));
            fpg_next   = PG_W'(page_of_addr);
            if (req_type == bpa_pkg::REQ_INIT)
                fc_next = '0;
            if (req_type == bpa_pkg::REQ_FREE)
                ptr_next = PG_W'(page_of_addr);
        end

        // Init sweep: one page per step over the whole map
        if (cmd.init_step)
        begin
            wr_en  = 1'b1;
            wr_val = !(ptr_reg >= first_reg && ptr_reg < total_reg);
            if (!wr_val)
                fc_next = fc_reg + 1'b1;
            ptr_next = ptr_reg + 1'b1;
        end

        // First-fit search: one page per step
        if (cmd.scan_step)
        begin
            if (rd_reg)
                run_next = '0;
            else
            begin
                if (run_reg == '0)
                    start_next = ptr_reg;
                run_next = run_reg + 1'b1;
                if (run_reg + 1'b1 == cnt_reg)
                    found_next = 1'b1;
            end
            if (!(found_next))
                ptr_next = ptr_reg + 1'b1;
            else
                ptr_next = start_next;
        end

        // Mark the found run used
        if (cmd.mark_step)
        begin
            wr_en    = 1'b1;
            wr_val   = 1'b1;
            ptr_next = ptr_reg + 1'b1;
            if (ptr_reg + 1'b1 == start_reg + cnt_reg)
                fc_next = fc_reg - bpa_pkg::CNT_W'(cnt_reg);
        end

        // Free one page if in range and used
        if (cmd.free_step)
        begin
            if (!oor_reg && rd_reg)
            begin
                wr_en   = 1'b1;
                wr_idx  = fpg_reg[IDX_W-1:0];
                wr_val  = 1'b0;
                fc_next = fc_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        sts.init_last = (ptr_reg == PG_W'(MAX_PAGES - 1));
        sts.scan_done = fail_reg || found_reg || (ptr_reg >= total_reg);
        sts.found     = found_reg && !fail_reg;
        sts.mark_last = (ptr_reg + 1'b1 == start_reg + cnt_reg);
    end

    assign base_wide = (ADDR_W_L+SH_W)'(start_reg) << SH_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg       <= '0;
            found_reg    <= 1'b0;
            fail_reg     <= 1'b0;
            oor_reg      <= 1'b0;
            req_reg      <= '0;
            ptr_reg      <= '0;
        end
        else
        begin
            fc_reg       <= fc_next;
            found_reg    <= found_next;
            fail_reg     <= fail_next;
            oor_reg      <= oor_next;
            req_reg      <= req_next;
            ptr_reg      <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        start_reg <= start_next;
        run_reg   <= run_next;
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
        fpg_reg   <= fpg_next;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            free_pages   <= fc_reg;
            status       <= 1'b0;
            base_address <= '0;
            if (req_reg == bpa_pkg::REQ_ALLOC)
            begin
                if (found_reg && !fail_reg)
                    base_address <= base_wide[ADDR_W_L-1:0];
                else
                    status <= 1'b1;
            end
        end
    end

endmodule

[sv/bpa_ctrl.sv]
// Request sequencer of the bitmap page allocator.
`timescale 1ns / 1ps

module bpa_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [bpa_pkg::REQ_W-1:0] req_type,
    output logic                      out_valid,
    input  logic                      out_stall,
    output bpa_pkg::bpa_cmd_t         cmd,
    input  bpa_pkg::bpa_sts_t         sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_FREE  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;
    localparam logic [2:0] ST_CLEAR = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       accept;

    // Take a request only when idle; a held result does not block it
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.init_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start = 1'b1;
                    case (req_type)
                        bpa_pkg::REQ_INIT:  state_next = ST_INIT;
                        bpa_pkg::REQ_ALLOC: state_next = ST_SCAN;
                        bpa_pkg::REQ_FREE:  state_next = ST_FREE;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_last)
                    state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                    state_next = sts.found ? ST_MARK : ST_DONE;
                else
                    cmd.scan_step = 1'b1;
            end
            ST_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (sts.mark_last)
                    state_next = ST_DONE;
            end
            ST_FREE:
            begin
                cmd.free_step = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold while the previous result still waits
                if (!ov_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

[sv/bitmap_page_allocator.sv]
// Top level of the bitmap first-fit page allocator.
// Init writes one page per cycle over the whole map; allocate scans for a first fit and then
// marks the found run; free clears one page; an unused request code only returns a result.
// One request at a time: the next is taken the cycle after its result is loaded;
// a result still held at the output delays the load of the following one.
// Reset: config to defaults, free count 0, then a pass marks every page used before the first request is taken.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
    parameter int unsigned MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
    parameter int unsigned PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [bpa_pkg::REQ_W-1:0]  req_type,
    input  logic [bpa_pkg::CNT_W-1:0]  page_count,
    input  logic [bpa_pkg::ADDR_W-1:0] free_address,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       status,
    output logic [bpa_pkg::ADDR_W-1:0] base_address,
    output logic [bpa_pkg::CNT_W-1:0]  free_pages,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bpa_pkg::CFG_W-1:0]  cfg_data
);

    logic [bpa_pkg::CFG_W-1:0] total_reg;
    logic [bpa_pkg::CFG_W-1:0] first_reg;
    bpa_pkg::bpa_cmd_t cmd;
    bpa_pkg::bpa_sts_t sts;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= bpa_pkg::CFG_W'(16384);
            first_reg <= bpa_pkg::CFG_W'(2048);
        end
        else if (cfg_we)
        begin
            if (cfg_index == bpa_pkg::CFG_TOTAL)
                total_reg <= cfg_data;
            else
                first_reg <= cfg_data;
        end
    end

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    bpa_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .page_count   (page_count),
        .free_address (free_address),
        .total_cfg    (total_reg),
        .first_cfg    (first_reg),
        .status       (status),
        .base_address (base_address),
        .free_pages   (free_pages)
    );

endmodule

[tb/tb_bitmap_page_allocator.sv]
// Self-checking testbench for the bitmap first-fit page allocator.
`timescale 1ns / 1ps

module tb_bitmap_page_allocator;

    localparam int unsigned NPAGES = bpa_pkg::MAX_PAGES_DEF;
    localparam int unsigned PBYTES = bpa_pkg::PAGE_BYTES_DEF;
    localparam int REQ_W  = bpa_pkg::REQ_W;
    localparam int CNT_W  = bpa_pkg::CNT_W;
    localparam int ADDR_W = bpa_pkg::ADDR_W;
    localparam int CFG_W  = bpa_pkg::CFG_W;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    typedef struct {
        logic              ok_fail;
        logic [ADDR_W-1:0] base;
        logic [CNT_W-1:0]  nfree;
    } alloc_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [REQ_W-1:0]  req_type = bpa_pkg::REQ_INIT;
    logic [CNT_W-1:0]  page_count = '0;
    logic [ADDR_W-1:0] free_address = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              status;
    logic [ADDR_W-1:0] base_address;
    logic [CNT_W-1:0]  free_pages;
    logic              cfg_we = 1'b0;
    logic              cfg_index = bpa_pkg::CFG_TOTAL;
    logic [CFG_W-1:0]  cfg_data = '0;

    // Shadow state of the allocator
    bit                used_map [NPAGES];
    logic [CFG_W-1:0]  sh_total;
    logic [CFG_W-1:0]  sh_first;
    logic [CNT_W-1:0]  sh_free;
    alloc_result_t     result_q [$];

    int  mismatches = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;
    int  hold_left = 0;

    bitmap_page_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .page_count(page_count), .free_address(free_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .base_address(base_address), .free_pages(free_pages),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop on a hung run
    initial
    begin
        #60_000_000;
        $display("tb_bitmap_page_allocator: FAIL");
        $finish;
    end

    function automatic int unsigned eff_total();
        return (sh_total > NPAGES) ? NPAGES : sh_total;
    endfunction

    // Work out the result of one accepted request and queue it
    function automatic void predict_request(logic [REQ_W-1:0] r, logic [CNT_W-1:0] c,
                                            logic [ADDR_W-1:0] a);
        alloc_result_t res;
        int unsigned tot;
        int unsigned run;
        int unsigned start;
        int unsigned pg;
        bit found;
        tot = eff_total();
        res.ok_fail = 1'b0;
        res.base = '0;
        run = 0;
        start = 0;
        found = 1'b0;
        if (r == bpa_pkg::REQ_INIT)
        begin
            for (int p = 0; p < NPAGES; p++)
                used_map[p] = 1'b1;
            sh_free = '0;
            for (int unsigned p = sh_first; p < tot; p++)
            begin
                used_map[p] = 1'b0;
                sh_free++;
            end
        end
        else if (r == bpa_pkg::REQ_ALLOC)
        begin
            if (c != 0 && c <= tot)
            begin
                for (int unsigned p = 0; p < tot && !found; p++)
                begin
                    if (used_map[p])
                        run = 0;
                    else
                    begin
                        if (run == 0)
                            start = p;
                        run++;
                        if (run == c)
                            found = 1'b1;
                    end
                end
            end
            if (found)
            begin
                for (int unsigned p = start; p < start + c; p++)
                    used_map[p] = 1'b1;
                sh_free -= c;
                res.base = start * PBYTES;
            end
            else
                res.ok_fail = 1'b1;
        end
        else if (r == bpa_pkg::REQ_FREE)
        begin
            pg = a / PBYTES;
            if (pg < tot && used_map[pg])
            begin
                used_map[pg] = 1'b0;
                sh_free++;
            end
        end
        res.nfree = sh_free;
        result_q.push_back(res);
    endfunction

    // Offer one request and hold it until taken
    task automatic send_req(logic [REQ_W-1:0] r, logic [CNT_W-1:0] c, logic [ADDR_W-1:0] a);
        @(negedge clk);
        if (tx_idle && $urandom_range(99) < 33)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = r;
        page_count = c;
        free_address = a;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(r, c, a);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(logic idx, logic [CFG_W-1:0] val);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == bpa_pkg::CFG_TOTAL)
            sh_total = val;
        else
            sh_first = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] page_addr(int unsigned pg);
        return pg * PBYTES + $urandom_range(PBYTES - 1);
    endfunction

    // Receiver: long hold-off when asked, otherwise random stalls while rx_idle is set
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= rx_idle && ($urandom_range(99) < 33);
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d base %h free %0d",
                             status, base_address, free_pages);
            end
            else
            begin
                exp_r = result_q.pop_front();
                if (status !== exp_r.ok_fail || base_address !== exp_r.base ||
                    free_pages !== exp_r.nfree)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st %0d base %h free %0d, got st %0d base %h free %0d",
                                 exp_r.ok_fail, exp_r.base, exp_r.nfree,
                                 status, base_address, free_pages);
                end
            end
        end
    end

    // Before any init every page is used, but frees still apply
    task automatic test_before_init();
        send_req(bpa_pkg::REQ_ALLOC, 15'd1, '0);
        send_req(bpa_pkg::REQ_FREE, '0, page_addr(5));
        send_req(bpa_pkg::REQ_FREE, '0, page_addr(5));
        send_req(bpa_pkg::REQ_FREE, '0, page_addr(6));
        send_req(bpa_pkg::REQ_ALLOC, 15'd2, '0);
        send_req(REQ_NONE, 15'h7FFF, 32'hFFFF_FFFF);
    endtask

    // Field extremes and each corner of allocate and free
    task automatic test_directed();
        cfg_write(bpa_pkg::CFG_TOTAL, 15'd64);
        cfg_write(bpa_pkg::CFG_FIRST, 15'd4);
        send_req(bpa_pkg::REQ_INIT, '0, '0);
        send_req(bpa_pkg::REQ_ALLOC, 15'd0, '0);
        send_req(bpa_pkg::REQ_ALLOC, 15'd65, '0);
        send_req(bpa_pkg::REQ_ALLOC, 15'h7FFF, '0);
        send_req(bpa_pkg::REQ_ALLOC, 15'd60, '0);
        send_req(bpa_pkg::REQ_ALLOC, 15'd1, '0);
        send_req(bpa_pkg::REQ_FREE, '0, page_addr(10));
        send_req(bpa_pkg::REQ_FREE, '0, page_addr(10));
        send_req(bpa_pkg::REQ_FREE, '0, 32'hFFFF_FFFF);
        send_req(bpa_pkg::REQ_FREE, '0, page_addr(63));
        send_req(bpa_pkg::REQ_FREE, '0, page_addr(64));
        send_req(bpa_pkg::REQ_ALLOC, 15'd2, '0);
        send_req(bpa_pkg::REQ_ALLOC, 15'd1, '0);
        // lowered total leaves page 40 counted but out of reach
        send_req(bpa_pkg::REQ_FREE, '0, page_addr(40));
        cfg_write(bpa_pkg::CFG_TOTAL, 15'd32);
        send_req(bpa_pkg::REQ_ALLOC, 15'd1, '0);
        send_req(bpa_pkg::REQ_ALLOC, 15'd33, '0);
        send_req(bpa_pkg::REQ_INIT, '0, '0);
        // start above total
        cfg_write(bpa_pkg::CFG_FIRST, 15'd100);
        send_req(bpa_pkg::REQ_INIT, '0, '0);
        cfg_write(bpa_pkg::CFG_TOTAL, 15'd0);
        send_req(bpa_pkg::REQ_INIT, '0, '0);
        send_req(bpa_pkg::REQ_ALLOC, 15'd1, '0);
        // total above capacity clamps
        cfg_write(bpa_pkg::CFG_TOTAL, 15'h7FFF);
        cfg_write(bpa_pkg::CFG_FIRST, 15'd16380);
        send_req(bpa_pkg::REQ_INIT, '0, '0);
        send_req(bpa_pkg::REQ_ALLOC, 15'd4, '0);
        send_req(bpa_pkg::REQ_FREE, '0, page_addr(16383));
        send_req(bpa_pkg::REQ_ALLOC, 15'd1, '0);
    endtask

    // Mixed allocate, free and unused-code traffic over a small managed range
    task automatic run_mix(int n, int unsigned tot);
        int unsigned sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 45)
                send_req(bpa_pkg::REQ_ALLOC, CNT_W'($urandom_range(1, 6)), $urandom());
            else if (sel < 50)
                send_req(bpa_pkg::REQ_ALLOC, CNT_W'($urandom_range(0, tot + 4)),
                         $urandom());
            else if (sel < 53)
                send_req(bpa_pkg::REQ_ALLOC, CNT_W'($urandom()), $urandom());
            else if (sel < 93)
                send_req(bpa_pkg::REQ_FREE, CNT_W'($urandom()),
                         page_addr($urandom_range(0, tot - 1)));
            else if (sel < 98)
                send_req(bpa_pkg::REQ_FREE, CNT_W'($urandom()), $urandom());
            else
                send_req(REQ_NONE, CNT_W'($urandom()), $urandom());
        end
    endtask

    task automatic test_random();
        int unsigned tot;
        for (int ph = 0; ph < 9; ph++)
        begin
            tot = $urandom_range(8, 256);
            tx_idle = (ph != 4);
            rx_idle = (ph != 4);
            cfg_write(bpa_pkg::CFG_TOTAL, CFG_W'(tot));
            cfg_write(bpa_pkg::CFG_FIRST, CFG_W'($urandom_range(0, tot / 2)));
            send_req(bpa_pkg::REQ_INIT, CNT_W'($urandom()), $urandom());
            run_mix(137, tot);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Receiver holds off while requests keep coming, then the sender waits out
    task automatic test_pressure();
        @(negedge clk);
        hold_left = 300;
        run_mix(8, eff_total() > 0 ? eff_total() : 1);
        drain();
        run_mix(8, eff_total() > 0 ? eff_total() : 1);
    endtask

    // Full-size map with the default reserved region
    task automatic test_full_size();
        cfg_write(bpa_pkg::CFG_TOTAL, 15'd16384);
        cfg_write(bpa_pkg::CFG_FIRST, 15'd2048);
        send_req(bpa_pkg::REQ_INIT, '0, '0);
        for (int i = 0; i < 6; i++)
            send_req(bpa_pkg::REQ_ALLOC, CNT_W'($urandom_range(1, 3)), '0);
        send_req(bpa_pkg::REQ_FREE, '0, page_addr(2049));
        send_req(bpa_pkg::REQ_ALLOC, 15'd1, '0);
        send_req(bpa_pkg::REQ_ALLOC, 15'd14300, '0);
    endtask

    initial
    begin
        for (int p = 0; p < NPAGES; p++)
            used_map[p] = 1'b1;
        sh_total = 15'd16384;
        sh_first = 15'd2048;
        sh_free = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_before_init();
        test_directed();
        test_random();
        test_pressure();
        test_full_size();
        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && result_q.size() == 0)
            $display("tb_bitmap_page_allocator: PASS");
        else
            $display("tb_bitmap_page_allocator: FAIL");
        $finish;
    end

endmodule
